### rtl/gts_pkg.sv
// Package for the groove tick sequencer: payload structs, command and state codes,
// field widths and table constants.
// No dependencies.
package gts_pkg;

   // Field widths of the request and response payloads
   localparam int CMD_W   = 3;
   localparam int CHAN_W  = 3;
   localparam int PAT_W   = 5;
   localparam int POS_W   = 4;
   localparam int TICK_W  = 8;
   localparam int MASK_W  = 8;

   // Default sizes handed to the top level
   localparam int DEF_CHANNELS = 8;
   localparam int DEF_GROOVES  = 32;
   localparam int DEF_STEPS    = 16;

   // Table contents
   localparam logic [TICK_W-1:0] END_MARK      = 8'hFF;
   localparam logic [TICK_W-1:0] DEFAULT_TICKS = 8'd6;
   localparam int                DEFAULT_LEN   = 2;  // leading steps that reset to DEFAULT_TICKS

   typedef enum logic [CMD_W-1:0] {
      CMD_WRITE  = 3'd0,
      CMD_SELECT = 3'd1,
      CMD_RESET  = 3'd2,
      CMD_TICK   = 3'd3,
      CMD_QUERY  = 3'd4
   } cmd_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_TICK_CHK,
      ST_TICK_NXT,
      ST_TICK_ZERO,
      ST_SEL_LOAD,
      ST_RST_RD,
      ST_RST_LOAD,
      ST_QRY_ADDR,
      ST_QRY_RD,
      ST_QRY_MOD,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [CMD_W-1:0]  command;
      logic [CHAN_W-1:0] channel;
      logic [PAT_W-1:0]  pattern_index;
      logic [POS_W-1:0]  step_index;
      logic [TICK_W-1:0] step_value;
   } req_type;

   typedef struct packed {
      logic [PAT_W-1:0]  pattern_out;
      logic [POS_W-1:0]  position_out;
      logic              fire;
      logic [MASK_W-1:0] stepped_mask;
   } rsp_type;

   // Status of the remainder unit toward the sequencer
   typedef struct packed {
      logic done;
      logic rem_zero;
   } mod_stat_type;

endpackage

### rtl/gts_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
module gts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write when enabled; read every cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/gts_mod_unit.sv
// Iterative 8-bit remainder unit: restoring division, one dividend bit per cycle.
// Depends on gts_pkg for the status struct and the tick width.
module gts_mod_unit (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [gts_pkg::TICK_W-1:0] dividend,
   input  logic [gts_pkg::TICK_W-1:0] divisor,
   output gts_pkg::mod_stat_type      stat
);

   localparam int W  = gts_pkg::TICK_W;
   localparam int CW = $clog2(W);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [W-1:0]  rem_ff, rem_in;
   logic [W-1:0]  num_ff, num_in;
   logic [W-1:0]  den_ff, den_in;
   logic [W:0]    trial;

   // Shift in the next dividend bit and subtract when it fits
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      trial   = {rem_ff, num_ff[W-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(W - 1);
         rem_in  = '0;
         num_in  = dividend;
         den_in  = divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = W'(trial - {1'b0, den_ff});
         end else begin
            rem_in = trial[W-1:0];
         end
         num_in = {num_ff[W-2:0], 1'b0};
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      num_ff <= num_in;
      den_ff <= den_in;
   end

   assign stat.done     = done_ff;
   assign stat.rem_zero = (rem_ff == '0);

endmodule

### rtl/groove_tick_sequencer_unit.sv
// Groove tick sequencer: after reset the pattern table is filled by a clearing pass over
// all GROOVES*STEPS entries (512 by default) during which req_ready stays low. Afterwards
// one command is taken at a time. A table write, an unknown command, or a select or
// query with an out-of-range channel or pattern goes straight to the finishing state;
// an accepted select loads its channel from step 0 of the pattern, a channel reset
// reads and reloads each channel in turn, a tick visits each channel in turn (a channel
// at zero reads its next step, and one more table read wraps it to step 0 on an end
// marker), and a query reads the current step and then waits on the remainder unit.
// All table accesses go through the one table RAM. One response is produced for every
// command; a finished response waits in an output register while the next command is
// already taken, and a command that finishes while that register is still held waits
// until it frees.
module groove_tick_sequencer_unit #(
   parameter int CHANNELS = gts_pkg::DEF_CHANNELS,
   parameter int GROOVES  = gts_pkg::DEF_GROOVES,
   parameter int STEPS    = gts_pkg::DEF_STEPS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  gts_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output gts_pkg::rsp_type rsp_data
);

   localparam int DEPTH  = GROOVES * STEPS;
   localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CIW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int PAT_W  = gts_pkg::PAT_W;
   localparam int POS_W  = gts_pkg::POS_W;
   localparam int TICK_W = gts_pkg::TICK_W;
   localparam int MASK_W = gts_pkg::MASK_W;

   gts_pkg::state_type    state_ff, state_in;
   gts_pkg::req_type      item_ff, item_in;
   gts_pkg::rsp_type      res_ff, res_in;
   gts_pkg::rsp_type      rsp_data_ff;
   logic                  rsp_valid_ff;
   logic                  rsp_free;
   logic [CIW-1:0]        cidx_ff, cidx_in;
   logic                  last_chan;
   logic [AW-1:0]         clr_addr_ff, clr_addr_in;
   logic [POS_W-1:0]      clr_step_ff, clr_step_in;
   logic                  clr_last;

   // Channel state
   logic [PAT_W-1:0]      chan_pat_ff [CHANNELS];
   logic [POS_W-1:0]      chan_pos_ff [CHANNELS];
   logic [TICK_W-1:0]     chan_tck_ff [CHANNELS];
   logic                  ch_we;
   logic [PAT_W-1:0]      ch_pat_wr;
   logic [POS_W-1:0]      ch_pos_wr;
   logic [TICK_W-1:0]     ch_tck_wr;
   logic [PAT_W-1:0]      cur_pat;
   logic [POS_W-1:0]      cur_pos;
   logic [TICK_W-1:0]     cur_tck;
   logic [POS_W-1:0]      npos;
   logic [MASK_W-1:0]     chan_bit;

   // Table RAM and remainder unit
   logic                  ram_we;
   logic [AW-1:0]         ram_waddr;
   logic [TICK_W-1:0]     ram_wdata;
   logic [AW-1:0]         ram_raddr;
   logic [TICK_W-1:0]     ram_rdata;
   logic                  mod_start;
   logic [TICK_W-1:0]     mod_den;
   gts_pkg::mod_stat_type mod_stat;

   logic                  req_chan_ok;
   logic                  req_pat_ok;
   logic                  req_step_ok;

   function automatic logic [AW-1:0] tbl_addr(input logic [PAT_W-1:0] pat,
                                              input logic [POS_W-1:0] pos);
      return AW'(pat) * AW'(STEPS) + AW'(pos);
   endfunction

   gts_ram #(
      .WIDTH (TICK_W),
      .DEPTH (DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   gts_mod_unit u_mod (
      .clock    (clock),
      .reset    (reset),
      .start    (mod_start),
      .dividend (cur_tck),
      .divisor  (mod_den),
      .stat     (mod_stat)
   );

   // Current channel view, all at the one sequencer index
   assign cur_pat   = chan_pat_ff[cidx_ff];
   assign cur_pos   = chan_pos_ff[cidx_ff];
   assign cur_tck   = chan_tck_ff[cidx_ff];
   assign npos      = (cur_pos == POS_W'(STEPS - 1)) ? '0 : cur_pos + 1'b1;
   assign chan_bit  = MASK_W'(1) << cidx_ff;
   assign last_chan = (cidx_ff == CIW'(CHANNELS - 1));
   assign clr_last  = (clr_addr_ff == AW'(DEPTH - 1));
   assign mod_den   = (ram_rdata == '0) ? TICK_W'(1) : ram_rdata;

   assign req_chan_ok = (int'(req_data.channel) < CHANNELS);
   assign req_pat_ok  = (int'(req_data.pattern_index) < GROOVES);
   assign req_step_ok = (int'(req_data.step_index) < STEPS);

   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == gts_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         gts_pkg::ST_CLEAR: begin
            if (clr_last) state_in = gts_pkg::ST_IDLE;
         end
         gts_pkg::ST_IDLE: begin
            if (req_valid) begin
               unique case (req_data.command)
                  gts_pkg::CMD_WRITE: state_in = gts_pkg::ST_FINISH;
                  gts_pkg::CMD_SELECT: begin
                     state_in = (req_chan_ok && req_pat_ok) ? gts_pkg::ST_SEL_LOAD
                                                            : gts_pkg::ST_FINISH;
                  end
                  gts_pkg::CMD_RESET: state_in = gts_pkg::ST_RST_RD;
                  gts_pkg::CMD_TICK:  state_in = gts_pkg::ST_TICK_CHK;
                  gts_pkg::CMD_QUERY: begin
                     state_in = req_chan_ok ? gts_pkg::ST_QRY_ADDR : gts_pkg::ST_FINISH;
                  end
                  default: state_in = gts_pkg::ST_FINISH;
               endcase
            end
         end
         gts_pkg::ST_TICK_CHK: begin
            if (cur_tck == '0) begin
               state_in = gts_pkg::ST_TICK_NXT;
            end else if (last_chan) begin
               state_in = gts_pkg::ST_FINISH;
            end
         end
         gts_pkg::ST_TICK_NXT: begin
            if (ram_rdata == gts_pkg::END_MARK) begin
               state_in = gts_pkg::ST_TICK_ZERO;
            end else begin
               state_in = last_chan ? gts_pkg::ST_FINISH : gts_pkg::ST_TICK_CHK;
            end
         end
         gts_pkg::ST_TICK_ZERO: begin
            state_in = last_chan ? gts_pkg::ST_FINISH : gts_pkg::ST_TICK_CHK;
         end
         gts_pkg::ST_SEL_LOAD: state_in = gts_pkg::ST_FINISH;
         gts_pkg::ST_RST_RD:   state_in = gts_pkg::ST_RST_LOAD;
         gts_pkg::ST_RST_LOAD: begin
            state_in = last_chan ? gts_pkg::ST_FINISH : gts_pkg::ST_RST_RD;
         end
         gts_pkg::ST_QRY_ADDR: state_in = gts_pkg::ST_QRY_RD;
         gts_pkg::ST_QRY_RD:   state_in = gts_pkg::ST_QRY_MOD;
         gts_pkg::ST_QRY_MOD: begin
            if (mod_stat.done) state_in = gts_pkg::ST_FINISH;
         end
         gts_pkg::ST_FINISH: begin
            if (rsp_free) state_in = gts_pkg::ST_IDLE;
         end
         default: state_in = gts_pkg::ST_IDLE;
      endcase
   end

   // Datapath controls per state
   always_comb begin
      item_in     = item_ff;
      res_in      = res_ff;
      cidx_in     = cidx_ff;
      clr_addr_in = clr_addr_ff;
      clr_step_in = clr_step_ff;
      ch_we       = 1'b0;
      ch_pat_wr   = cur_pat;
      ch_pos_wr   = cur_pos;
      ch_tck_wr   = cur_tck;
      ram_we      = 1'b0;
      ram_waddr   = tbl_addr(item_ff.pattern_index, item_ff.step_index);
      ram_wdata   = item_ff.step_value;
      ram_raddr   = tbl_addr(cur_pat, npos);
      mod_start   = 1'b0;
      unique case (state_ff)
         gts_pkg::ST_CLEAR: begin
            // Sweep the table with its reset contents
            ram_we      = 1'b1;
            ram_waddr   = clr_addr_ff;
            ram_wdata   = (int'(clr_step_ff) < gts_pkg::DEFAULT_LEN) ? gts_pkg::DEFAULT_TICKS
                                                                      : gts_pkg::END_MARK;
            clr_addr_in = clr_addr_ff + 1'b1;
            clr_step_in = (clr_step_ff == POS_W'(STEPS - 1)) ? '0 : clr_step_ff + 1'b1;
         end
         gts_pkg::ST_IDLE: begin
            ram_raddr = tbl_addr(req_data.pattern_index, '0);
            if (req_valid) begin
               item_in = req_data;
               res_in  = '0;
               cidx_in = '0;
               if (req_data.command == gts_pkg::CMD_SELECT ||
                   req_data.command == gts_pkg::CMD_QUERY) begin
                  cidx_in = CIW'(req_data.channel);
               end
               if (req_data.command == gts_pkg::CMD_WRITE && req_pat_ok && req_step_ok) begin
                  ram_we    = 1'b1;
                  ram_waddr = tbl_addr(req_data.pattern_index, req_data.step_index);
                  ram_wdata = req_data.step_value;
               end
            end
         end
         gts_pkg::ST_TICK_CHK: begin
            // Count down a running channel; a channel at zero reads its next step
            if (cur_tck != '0) begin
               ch_we     = 1'b1;
               ch_tck_wr = cur_tck - 1'b1;
               if (!last_chan) cidx_in = cidx_ff + 1'b1;
            end
         end
         gts_pkg::ST_TICK_NXT: begin
            ram_raddr = tbl_addr(cur_pat, '0);
            if (ram_rdata != gts_pkg::END_MARK) begin
               ch_we     = 1'b1;
               ch_pos_wr = npos;
               ch_tck_wr = ram_rdata - 1'b1;
               res_in.stepped_mask = res_ff.stepped_mask | chan_bit;
               if (!last_chan) cidx_in = cidx_ff + 1'b1;
            end
         end
         gts_pkg::ST_TICK_ZERO: begin
            // End marker: wrap to step 0
            ch_we     = 1'b1;
            ch_pos_wr = '0;
            ch_tck_wr = ram_rdata - 1'b1;
            res_in.stepped_mask = res_ff.stepped_mask | chan_bit;
            if (!last_chan) cidx_in = cidx_ff + 1'b1;
         end
         gts_pkg::ST_SEL_LOAD: begin
            ch_we     = 1'b1;
            ch_pat_wr = item_ff.pattern_index;
            ch_pos_wr = '0;
            ch_tck_wr = ram_rdata;
         end
         gts_pkg::ST_RST_RD: begin
            ram_raddr = tbl_addr(cur_pat, '0);
         end
         gts_pkg::ST_RST_LOAD: begin
            ch_we     = 1'b1;
            ch_pos_wr = '0;
            ch_tck_wr = ram_rdata;
            if (!last_chan) cidx_in = cidx_ff + 1'b1;
         end
         gts_pkg::ST_QRY_ADDR: begin
            ram_raddr = tbl_addr(cur_pat, cur_pos);
         end
         gts_pkg::ST_QRY_RD: begin
            mod_start           = 1'b1;
            res_in.pattern_out  = cur_pat;
            res_in.position_out = cur_pos;
         end
         gts_pkg::ST_QRY_MOD: begin
            if (mod_stat.done) res_in.fire = mod_stat.rem_zero;
         end
         gts_pkg::ST_FINISH: begin
         end
         default: begin
         end
      endcase
   end

   // Control registers and working payload
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= gts_pkg::ST_CLEAR;
         clr_addr_ff <= '0;
         clr_step_ff <= '0;
         cidx_ff     <= '0;
      end else begin
         state_ff    <= state_in;
         clr_addr_ff <= clr_addr_in;
         clr_step_ff <= clr_step_in;
         cidx_ff     <= cidx_in;
      end
      item_ff <= item_in;
      res_ff  <= res_in;
   end

   // Channel state: reset to pattern 0, step 0, default count
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            chan_pat_ff[i] <= '0;
            chan_pos_ff[i] <= '0;
            chan_tck_ff[i] <= gts_pkg::DEFAULT_TICKS;
         end
      end else if (ch_we) begin
         chan_pat_ff[cidx_ff] <= ch_pat_wr;
         chan_pos_ff[cidx_ff] <= ch_pos_wr;
         chan_tck_ff[cidx_ff] <= ch_tck_wr;
      end
   end

   // Output register: load on finish, drop on transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == gts_pkg::ST_FINISH && rsp_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (state_ff == gts_pkg::ST_FINISH && rsp_free) begin
         rsp_data_ff <= res_ff;
      end
   end

endmodule

### tb/tb_groove_tick_sequencer_unit.sv
// Self-checking testbench for groove_tick_sequencer_unit: directed and random command
// streams over valid/ready, predicted per transfer and compared against each response.
// Depends on gts_pkg and the sequencer RTL.
`timescale 1ns / 100ps

module tb_groove_tick_sequencer_unit;

   localparam int TABLE_DEPTH     = gts_pkg::DEF_GROOVES * gts_pkg::DEF_STEPS;
   localparam int CMD_FIRST_SPARE = 5;
   localparam int CMD_LAST_SPARE  = 7;
   localparam int HOLDOFF_CYCLES  = 300;
   localparam int QUIET_CYCLES    = 40;
   localparam int CYCLE_LIMIT     = 200000;
   localparam int REPORT_LIMIT    = 10;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   gts_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   gts_pkg::rsp_type rsp_data;

   // Predicted sequencer state
   logic [gts_pkg::TICK_W-1:0] groove_table [TABLE_DEPTH];
   logic [gts_pkg::PAT_W-1:0]  chan_pat [gts_pkg::DEF_CHANNELS];
   logic [gts_pkg::POS_W-1:0]  chan_pos [gts_pkg::DEF_CHANNELS];
   logic [gts_pkg::TICK_W-1:0] chan_cnt [gts_pkg::DEF_CHANNELS];

   gts_pkg::rsp_type awaited_rsp [$];
   int      mismatch_count  = 0;
   int      send_idle_pct   = 0;
   int      rsp_stall_pct   = 0;
   int      holdoff_request = 0;
   int      holdoff_left    = 0;
   int      cycle_count     = 0;

   groove_tick_sequencer_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Apply one command to the predicted state and return its response
   function automatic gts_pkg::rsp_type predict_step(input gts_pkg::req_type item);
      gts_pkg::rsp_type           rsp;
      int                         base;
      int                         next;
      int                         ch;
      logic [gts_pkg::TICK_W-1:0] len;
      rsp = '0;
      ch  = int'(item.channel);
      case (item.command)
         gts_pkg::CMD_WRITE: begin
            if (int'(item.pattern_index) < gts_pkg::DEF_GROOVES &&
                int'(item.step_index) < gts_pkg::DEF_STEPS)
               groove_table[int'(item.pattern_index) * gts_pkg::DEF_STEPS +
                            int'(item.step_index)] = item.step_value;
         end
         gts_pkg::CMD_SELECT: begin
            if (int'(item.pattern_index) < gts_pkg::DEF_GROOVES &&
                ch < gts_pkg::DEF_CHANNELS) begin
               chan_pat[ch] = item.pattern_index;
               chan_pos[ch] = '0;
               chan_cnt[ch] = groove_table[int'(item.pattern_index) * gts_pkg::DEF_STEPS];
            end
         end
         gts_pkg::CMD_RESET: begin
            for (int c = 0; c < gts_pkg::DEF_CHANNELS; c++) begin
               chan_pos[c] = '0;
               chan_cnt[c] = groove_table[int'(chan_pat[c]) * gts_pkg::DEF_STEPS];
            end
         end
         gts_pkg::CMD_TICK: begin
            // Step channels whose counter ran out, wrapping on an end marker
            for (int c = 0; c < gts_pkg::DEF_CHANNELS; c++) begin
               base = int'(chan_pat[c]) * gts_pkg::DEF_STEPS;
               if (chan_cnt[c] == '0) begin
                  next = (int'(chan_pos[c]) + 1) % gts_pkg::DEF_STEPS;
                  if (groove_table[base + next] == gts_pkg::END_MARK)
                     next = 0;
                  chan_pos[c] = gts_pkg::POS_W'(next);
                  chan_cnt[c] = groove_table[base + next];
                  rsp.stepped_mask[c] = 1'b1;
               end
               chan_cnt[c] = chan_cnt[c] - 1'b1;
            end
         end
         gts_pkg::CMD_QUERY: begin
            if (ch < gts_pkg::DEF_CHANNELS) begin
               len = groove_table[int'(chan_pat[ch]) * gts_pkg::DEF_STEPS +
                                  int'(chan_pos[ch])];
               rsp.pattern_out  = chan_pat[ch];
               rsp.position_out = chan_pos[ch];
               // A zero length counts as one, so it always fires
               rsp.fire = (len == '0) ? 1'b1 : ((chan_cnt[ch] % len) == '0);
            end
         end
         default: ;
      endcase
      return rsp;
   endfunction

   function automatic gts_pkg::req_type make_cmd(input logic [gts_pkg::CMD_W-1:0] op,
                                                 input logic [gts_pkg::CHAN_W-1:0] ch,
                                                 input logic [gts_pkg::PAT_W-1:0] pat,
                                                 input logic [gts_pkg::POS_W-1:0] stp,
                                                 input logic [gts_pkg::TICK_W-1:0] val);
      gts_pkg::req_type item;
      item.command       = op;
      item.channel       = ch;
      item.pattern_index = pat;
      item.step_index    = stp;
      item.step_value    = val;
      return item;
   endfunction

   // Weighted random command, biased toward a few patterns and short step counts
   function automatic gts_pkg::req_type next_random_cmd();
      int                         pick;
      logic [gts_pkg::CMD_W-1:0]  op;
      logic [gts_pkg::PAT_W-1:0]  pat;
      logic [gts_pkg::TICK_W-1:0] val;
      pick = $urandom_range(99);
      if (pick < 40)      op = gts_pkg::CMD_TICK;
      else if (pick < 65) op = gts_pkg::CMD_QUERY;
      else if (pick < 80) op = gts_pkg::CMD_WRITE;
      else if (pick < 90) op = gts_pkg::CMD_SELECT;
      else if (pick < 95) op = gts_pkg::CMD_RESET;
      else op = gts_pkg::CMD_W'($urandom_range(CMD_LAST_SPARE, CMD_FIRST_SPARE));
      pat = ($urandom_range(3) == 0) ? gts_pkg::PAT_W'($urandom)
                                     : gts_pkg::PAT_W'($urandom_range(3));
      val = ($urandom_range(3) == 0) ? gts_pkg::TICK_W'($urandom)
                                     : gts_pkg::TICK_W'($urandom_range(5));
      return make_cmd(op, gts_pkg::CHAN_W'($urandom), pat, gts_pkg::POS_W'($urandom), val);
   endfunction

   task automatic log_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
         $display("[%0t] mismatch: %s", $realtime, msg);
   endtask

   // Offer one command after a random idle gap; record its response on transfer
   task automatic send_command(input gts_pkg::req_type item);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct)
         gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do
         @(posedge clock);
      while (!req_ready);
      awaited_rsp.push_back(predict_step(item));
   endtask

   // Hold the sender until every outstanding response has arrived
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (awaited_rsp.size() != 0)
         @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   // Responder: random stalls, or a long hold-off on request
   always @(posedge clock) begin
      if (holdoff_request > 0) begin
         holdoff_left    = holdoff_request;
         holdoff_request = 0;
      end
      if (holdoff_left > 0) begin
         holdoff_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Compare each response transfer with the oldest prediction
   always @(posedge clock) begin
      gts_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_rsp.size() == 0) begin
            log_mismatch($sformatf("unexpected response %p", rsp_data));
         end else begin
            want = awaited_rsp.pop_front();
            if (rsp_data.pattern_out !== want.pattern_out ||
                rsp_data.position_out !== want.position_out ||
                rsp_data.fire !== want.fire ||
                rsp_data.stepped_mask !== want.stepped_mask)
               log_mismatch($sformatf(
                  "pattern %0d/%0d position %0d/%0d fire %0b/%0b mask %02h/%02h (got/exp)",
                  rsp_data.pattern_out, want.pattern_out,
                  rsp_data.position_out, want.position_out,
                  rsp_data.fire, want.fire,
                  rsp_data.stepped_mask, want.stepped_mask));
         end
      end
   end

   // Power-up values: queries on both edge channels, one quiet tick
   task automatic test_reset_state();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      send_command(make_cmd(gts_pkg::CMD_QUERY, 3'd0, '0, '0, '0));
      send_command(make_cmd(gts_pkg::CMD_QUERY, 3'd7, '0, '0, '0));
      send_command(make_cmd(gts_pkg::CMD_TICK, '0, '0, '0, '0));
   endtask

   // Table writes at the corners of pattern, step and value
   task automatic test_table_edges();
      send_command(make_cmd(gts_pkg::CMD_WRITE, 3'd7, 5'd31, 4'd15, 8'd0));
      send_command(make_cmd(gts_pkg::CMD_WRITE, 3'd0, 5'd0, 4'd0, 8'd0));
      send_command(make_cmd(gts_pkg::CMD_WRITE, 3'd0, 5'd0, 4'd1, gts_pkg::END_MARK));
   endtask

   // Zero-length step, wrap on an end marker and counter underflow
   task automatic test_zero_length_wrap();
      send_command(make_cmd(gts_pkg::CMD_SELECT, 3'd7, 5'd0, '0, '0));
      send_command(make_cmd(gts_pkg::CMD_TICK, '0, '0, '0, '0));
      send_command(make_cmd(gts_pkg::CMD_QUERY, 3'd7, '0, '0, '0));
      send_command(make_cmd(gts_pkg::CMD_QUERY, 3'd2, '0, '0, '0));
   endtask

   // End marker at step zero loads as a count
   task automatic test_end_marker_start();
      send_command(make_cmd(gts_pkg::CMD_WRITE, '0, 5'd5, 4'd0, gts_pkg::END_MARK));
      send_command(make_cmd(gts_pkg::CMD_SELECT, 3'd3, 5'd5, '0, '0));
      send_command(make_cmd(gts_pkg::CMD_QUERY, 3'd3, '0, '0, '0));
   endtask

   // Rewind all channels after a tick has counted them down
   task automatic test_channel_reset();
      send_command(make_cmd(gts_pkg::CMD_WRITE, '0, 5'd31, 4'd2, 8'd1));
      send_command(make_cmd(gts_pkg::CMD_SELECT, 3'd0, 5'd31, '0, '0));
      send_command(make_cmd(gts_pkg::CMD_TICK, '0, '0, '0, '0));
      send_command(make_cmd(gts_pkg::CMD_QUERY, 3'd7, '0, '0, '0));
      send_command(make_cmd(gts_pkg::CMD_RESET, '1, '1, '1, '1));
      send_command(make_cmd(gts_pkg::CMD_QUERY, 3'd0, '0, '0, '0));
   endtask

   // Spare command codes answer zeros and leave state alone
   task automatic test_unknown_commands();
      for (int code = CMD_FIRST_SPARE; code <= CMD_LAST_SPARE; code++)
         send_command(make_cmd(gts_pkg::CMD_W'(code), '1, '1, '1, '1));
      send_command(make_cmd(gts_pkg::CMD_QUERY, 3'd0, '0, '0, '0));
      wait_for_drain();
   endtask

   // Stall the response side long enough to back up the request side
   task automatic test_output_holdoff();
      send_idle_pct   = 0;
      rsp_stall_pct   = 0;
      holdoff_request = HOLDOFF_CYCLES;
      repeat (16) send_command(next_random_cmd());
      wait_for_drain();
   endtask

   // Random traffic: mostly programmed grooves driven by ticks and queries
   task automatic test_random_grooves(input int idle_pct, input int stall_pct,
                                      input int item_total);
      int sent;
      int pat;
      int len;
      int nsel;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      sent = 0;
      while (sent < item_total) begin
         if ($urandom_range(23) == 0) begin
            // Program a short pattern, terminate it if shorter than a row, then move channels onto it
            pat = ($urandom_range(3) == 0) ? $urandom_range(gts_pkg::DEF_GROOVES - 1)
                                           : $urandom_range(3);
            len = $urandom_range(gts_pkg::DEF_STEPS, 1);
            for (int s = 0; s < len; s++)
               send_command(make_cmd(gts_pkg::CMD_WRITE, gts_pkg::CHAN_W'($urandom),
                                     gts_pkg::PAT_W'(pat), gts_pkg::POS_W'(s),
                                     gts_pkg::TICK_W'($urandom_range(4))));
            if (len < gts_pkg::DEF_STEPS)
               send_command(make_cmd(gts_pkg::CMD_WRITE, gts_pkg::CHAN_W'($urandom),
                                     gts_pkg::PAT_W'(pat), gts_pkg::POS_W'(len),
                                     gts_pkg::END_MARK));
            nsel = $urandom_range(3, 1);
            repeat (nsel)
               send_command(make_cmd(gts_pkg::CMD_SELECT, gts_pkg::CHAN_W'($urandom),
                                     gts_pkg::PAT_W'(pat), gts_pkg::POS_W'($urandom),
                                     gts_pkg::TICK_W'($urandom)));
            sent += len + 1 + nsel;
         end else begin
            send_command(next_random_cmd());
            sent++;
         end
      end
      wait_for_drain();
   endtask

   // Watchdog: end the run once it reaches the cycle limit
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Mismatches found");
      $finish;
   end

   initial begin
      // Predicted state after reset
      for (int i = 0; i < TABLE_DEPTH; i++)
         groove_table[i] = ((i % gts_pkg::DEF_STEPS) < gts_pkg::DEFAULT_LEN)
                           ? gts_pkg::DEFAULT_TICKS : gts_pkg::END_MARK;
      for (int c = 0; c < gts_pkg::DEF_CHANNELS; c++) begin
         chan_pat[c] = '0;
         chan_pos[c] = '0;
         chan_cnt[c] = gts_pkg::DEFAULT_TICKS;
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_table_edges();
      test_zero_length_wrap();
      test_end_marker_start();
      test_channel_reset();
      test_unknown_commands();
      test_output_holdoff();
      test_random_grooves(0, 0, 110);
      test_random_grooves(61, 0, 110);
      test_random_grooves(0, 61, 110);
      test_random_grooves(18, 18, 110);

      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

### groove_tick_sequencer_unit.f
rtl/gts_pkg.sv
rtl/gts_ram.sv
rtl/gts_mod_unit.sv
rtl/groove_tick_sequencer_unit.sv
tb/tb_groove_tick_sequencer_unit.sv
